/* design/atd_pkg.sv */
// ----------------------------------------------------------------------------
// atd_pkg
// Shared widths, register indexes and types of the adaptive threshold tone
// detector.
// ----------------------------------------------------------------------------
package atd_pkg;

  localparam int SampleWidth  = 24;
  localparam int ThrWidth     = SampleWidth - 1;
  localparam int RunWidth     = 8;
  localparam int CfgAddrWidth = 8;
  localparam int CfgDataWidth = 32;

  // stream payload widths, rounded up to whole bytes
  localparam int InDataWidth  = ((SampleWidth + 1 + 7) / 8) * 8;
  localparam int OutDataWidth = ((ThrWidth + 1 + 7) / 8) * 8;

  // register indexes
  localparam logic [CfgAddrWidth-1:0] RegMinThreshold   = CfgAddrWidth'(0);
  localparam logic [CfgAddrWidth-1:0] RegMaxThreshold   = CfgAddrWidth'(1);
  localparam logic [CfgAddrWidth-1:0] RegThresholdOffst = CfgAddrWidth'(2);
  localparam logic [CfgAddrWidth-1:0] RegRunLimit       = CfgAddrWidth'(3);

  // reset values
  localparam logic [ThrWidth-1:0] ResetMinThreshold = ThrWidth'(23488);
  localparam logic [ThrWidth-1:0] ResetMaxThreshold = ThrWidth'(251658);
  localparam logic [ThrWidth-1:0] ResetOffset       = ThrWidth'(10066);
  localparam logic [RunWidth-1:0] ResetRunLimit     = RunWidth'(18);
  localparam logic [ThrWidth-1:0] ResetThreshold    = ThrWidth'(33554);

  typedef struct packed {
    logic [ThrWidth-1:0] min_threshold;
    logic [ThrWidth-1:0] max_threshold;
    logic [ThrWidth-1:0] threshold_offset;
    logic [RunWidth-1:0] run_limit;
  } cfg_t;

endpackage

/* design/atd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// atd_cfg_regs
// Configuration register file: decodes index writes into the detector limits.
// ----------------------------------------------------------------------------
module atd_cfg_regs import atd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_threshold    <= ResetMinThreshold;
      cfg_q.max_threshold    <= ResetMaxThreshold;
      cfg_q.threshold_offset <= ResetOffset;
      cfg_q.run_limit        <= ResetRunLimit;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        RegMinThreshold:   cfg_q.min_threshold    <= cfg_data_i[ThrWidth-1:0];
        RegMaxThreshold:   cfg_q.max_threshold    <= cfg_data_i[ThrWidth-1:0];
        RegThresholdOffst: cfg_q.threshold_offset <= cfg_data_i[ThrWidth-1:0];
        RegRunLimit:       cfg_q.run_limit        <= cfg_data_i[RunWidth-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

endmodule

/* design/adaptive_threshold_tone_detector.sv */
// ----------------------------------------------------------------------------
// adaptive_threshold_tone_detector
// Peak-adaptive threshold with a debounced tone-present flag.
// ----------------------------------------------------------------------------
// One result beat per sample beat. A sample is captured in an input register
// and processed by compare and subtract logic into the output register, so the
// block sustains one sample per clock while the output is not stalled. The
// input register frees as soon as the output register can take its result, so
// a new sample is accepted while a finished result waits. Each result carries
// the detection flag held before that sample and the threshold used for it.
module adaptive_threshold_tone_detector import atd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // tdata: sample [SampleWidth-1:0], adapt_enable [SampleWidth], zero pad
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // tdata: detected [0], threshold_now [ThrWidth:1], zero pad
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OutDataWidth-1:0] m_axis_tdata,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  cfg_t cfg;

  atd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input register
  logic                          in_valid_q;
  logic signed [SampleWidth-1:0] in_sample_q;
  logic                          in_adapt_q;

  // detector state
  logic signed [SampleWidth-1:0] peak_q, peak_d;
  logic [ThrWidth-1:0]           thr_q, thr_d;
  logic                          det_q, det_d;
  logic [RunWidth-1:0]           run_q, run_d;

  // output register
  logic                out_valid_q;
  logic                out_det_q;
  logic [ThrWidth-1:0] out_thr_q;

  logic advance;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample_q <= s_axis_tdata[SampleWidth-1:0];
      in_adapt_q  <= s_axis_tdata[SampleWidth];
    end
  end

  // single-pass update
  logic signed [SampleWidth-1:0] max_ext, min_ext, thr_ext;
  logic signed [SampleWidth:0]   diff;
  logic                          past;
  logic [RunWidth-1:0]           run_inc;

  always_comb begin
    max_ext = signed'({1'b0, cfg.max_threshold});
    min_ext = signed'({1'b0, cfg.min_threshold});
    peak_d  = peak_q;
    thr_d   = thr_q;
    diff    = '0;
    if (in_adapt_q) begin
      if ((in_sample_q > peak_q) && (in_sample_q < max_ext)) begin
        peak_d = in_sample_q;
      end
      diff = {peak_d[SampleWidth-1], peak_d} - signed'({2'b00, cfg.threshold_offset});
      // max clamp first, min clamp wins when the limits cross
      if (diff > signed'({2'b00, cfg.max_threshold})) begin
        diff = signed'({2'b00, cfg.max_threshold});
      end
      if (diff < signed'({2'b00, cfg.min_threshold})) begin
        diff = signed'({2'b00, cfg.min_threshold});
      end
      thr_d = diff[ThrWidth-1:0];
    end else begin
      peak_d = min_ext;
    end

    thr_ext = signed'({1'b0, thr_d});
    past    = det_q ? (in_sample_q < thr_ext) : (in_sample_q > thr_ext);
    run_inc = (run_q == {RunWidth{1'b1}}) ? run_q : run_q + RunWidth'(1);
    run_d   = past ? run_inc : '0;
    det_d   = det_q;
    if (run_d > cfg.run_limit) begin
      det_d = !det_q;
      run_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q      <= '0;
      thr_q       <= ResetThreshold;
      det_q       <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        peak_q <= peak_d;
        thr_q  <= thr_d;
        det_q  <= det_d;
        run_q  <= run_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_det_q <= det_q;
      out_thr_q <= thr_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    m_axis_tdata              = '0;
    m_axis_tdata[0]           = out_det_q;
    m_axis_tdata[ThrWidth:1]  = out_thr_q;
  end

  // a toggle of the detection flag always restarts the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (det_q != $past(det_q)) |-> (run_q == '0))
    else $error("detection toggled without clearing the run count");

  // state only moves when a sample is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(det_q) && $stable(run_q) && $stable(thr_q)))
    else $error("detector state changed without a processed sample");

  // a new result beat needs a captured sample behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(in_valid_q))
    else $error("result beat raised without an input sample");

  // input stalls only behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while the output could advance");

endmodule

/* tb/tb_adaptive_threshold_tone_detector.sv */
// ----------------------------------------------------------------------------
// tb_adaptive_threshold_tone_detector
// Self-checking bench for the adaptive threshold tone detector. Sample beats
// go in over the input stream, and a predictor in the scoreboard keeps its own
// copy of the peak, threshold, run count and detection flag. The bench checks
// each output beat against the oldest predicted beat. A short directed part
// covers the clamps, crossed limits and the equal-to-threshold case. Random
// phases under several register settings follow, with tone bursts, quiet
// stretches and noise, and both sides stall at random but in the last phase.
// ----------------------------------------------------------------------------
module tb_adaptive_threshold_tone_detector import atd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 2000;
  localparam longint SampleMax = (64'sd1 <<< (SampleWidth - 1)) - 1;
  localparam longint SampleMin = -(64'sd1 <<< (SampleWidth - 1));
  localparam longint ThrMax = (64'sd1 <<< ThrWidth) - 1;
  // indexes with no register behind them
  localparam logic [CfgAddrWidth-1:0] RegUnmapped = CfgAddrWidth'(4);
  localparam logic [CfgAddrWidth-1:0] RegTopIndex = {CfgAddrWidth{1'b1}};

  typedef struct {
    logic                detected;
    logic [ThrWidth-1:0] threshold;
  } tone_result_t;

  class tone_detector_scoreboard;
    longint min_thr, max_thr, offset;
    int     run_limit;
    longint peak, threshold;
    bit     detected;
    int     run_len;
    int     mismatches;
    tone_result_t due_results[$];

    function new();
      min_thr   = longint'(ResetMinThreshold);
      max_thr   = longint'(ResetMaxThreshold);
      offset    = longint'(ResetOffset);
      run_limit = int'(ResetRunLimit);
      peak      = 0;
      threshold = longint'(ResetThreshold);
      detected  = 1'b0;
      run_len   = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    function void write_reg(logic [CfgAddrWidth-1:0] addr, logic [CfgDataWidth-1:0] data);
      case (addr)
        RegMinThreshold:   min_thr = longint'(data[ThrWidth-1:0]);
        RegMaxThreshold:   max_thr = longint'(data[ThrWidth-1:0]);
        RegThresholdOffst: offset = longint'(data[ThrWidth-1:0]);
        RegRunLimit:       run_limit = int'(data[RunWidth-1:0]);
        default: ;
      endcase
    endfunction

    // advance the detector by one sample and queue the beat it produces
    function void note_sample(logic [SampleWidth-1:0] smp, logic adapt);
      logic signed [SampleWidth-1:0] smp_s;
      longint s, t;
      bit held, past;
      tone_result_t res;
      smp_s = smp;
      s = smp_s;
      held = detected;
      if (adapt) begin
        if (s > peak && s < max_thr) peak = s;
        t = peak - offset;
        if (t > max_thr) t = max_thr;
        // min clamp comes last, so it wins when the limits cross
        if (t < min_thr) t = min_thr;
        threshold = t;
      end else begin
        peak = min_thr;
      end
      past = held ? (s < threshold) : (s > threshold);
      if (!past) run_len = 0;
      else if (run_len < 255) run_len++;
      if (run_len > run_limit) begin
        detected = !held;
        run_len = 0;
      end
      res.detected = held;
      res.threshold = threshold[ThrWidth-1:0];
      due_results.push_back(res);
    endfunction

    function void check_result(logic [OutDataWidth-1:0] beat);
      tone_result_t want;
      if (due_results.size() == 0) begin
        flag($sformatf("output beat %h with no sample pending", beat));
        return;
      end
      want = due_results.pop_front();
      if (beat[0] !== want.detected || beat[ThrWidth:1] !== want.threshold)
        flag($sformatf("detected exp %0b got %0b, threshold exp %0d got %0d",
                       want.detected, beat[0], want.threshold, beat[ThrWidth:1]));
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgAddrWidth-1:0] cfg_addr_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  tone_detector_scoreboard sb = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_left = 0;

  wire in_beat  = s_axis_tvalid && s_axis_tready;
  wire out_beat = m_axis_tvalid && m_axis_tready;
  wire cfg_beat = cfg_valid_i && cfg_ready_o;

  adaptive_threshold_tone_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (out_beat) sb.check_result(m_axis_tdata);
    if (in_beat) sb.note_sample(s_axis_tdata[SampleWidth-1:0], s_axis_tdata[SampleWidth]);
    if (cfg_beat) sb.write_reg(cfg_addr_i, cfg_data_i);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (in_beat || out_beat || cfg_beat) quiet = 0;
      else quiet++;
    end
    $display("adaptive_threshold_tone_detector: mismatch");
    $finish;
  end

  // output side pacing; a requested hold-off wins over random stalls
  initial begin : sink_pacing
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [InDataWidth-1:0] sample_beat(longint s, bit adapt);
    if (s > SampleMax) s = SampleMax;
    else if (s < SampleMin) s = SampleMin;
    return InDataWidth'({adapt, s[SampleWidth-1:0]});
  endfunction

  task automatic send_sample(longint s, bit adapt);
    int gap;
    gap = 0;
    if (tx_idle && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 11);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= sample_beat(s, adapt);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgAddrWidth-1:0] addr, logic [CfgDataWidth-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // upper data bits are junk on purpose; the block must mask them
  task automatic program_regs(logic [ThrWidth-1:0] mn, logic [ThrWidth-1:0] mx,
                              logic [ThrWidth-1:0] off, logic [RunWidth-1:0] lim);
    cfg_write(RegMinThreshold, {(CfgDataWidth - ThrWidth)'($urandom), mn});
    cfg_write(RegMaxThreshold, {(CfgDataWidth - ThrWidth)'($urandom), mx});
    cfg_write(RegThresholdOffst, {(CfgDataWidth - ThrWidth)'($urandom), off});
    cfg_write(RegRunLimit, {(CfgDataWidth - RunWidth)'($urandom), lim});
  endtask

  // drop valid and wait until every predicted beat has come out
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic play_random(int n, int hold_at);
    int left, kind;
    longint s;
    bit ad;
    logic signed [SampleWidth-1:0] raw;
    left = 0;
    kind = 0;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_left = 80;
      if (left == 0) begin
        kind = $urandom_range(0, 9);
        left = $urandom_range(1, sb.run_limit + 12);
      end
      left--;
      if (kind <= 4) begin
        // tone burst: keep samples on the far side of the threshold
        ad = 1'b0;
        if (sb.detected) s = sb.threshold - longint'($urandom_range(1, 3000));
        else s = sb.threshold + longint'($urandom_range(1, 3000));
      end else if (kind <= 6) begin
        // quiet stretch: let the peak and threshold adapt
        ad = 1'b1;
        if ($urandom_range(0, 3) == 0) s = longint'($urandom_range(0, ThrMax));
        else s = sb.max_thr - longint'($urandom_range(0, 5000));
      end else if (kind == 7) begin
        // hover around the threshold, hitting it exactly now and then
        ad = 1'($urandom_range(0, 1));
        s = sb.threshold + longint'($urandom_range(0, 6)) - 3;
      end else begin
        ad = 1'($urandom_range(0, 1));
        raw = SampleWidth'($urandom);
        s = raw;
      end
      send_sample(s, ad);
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: peak minus offset below zero, peak rejected at max, equal sample
    send_sample(SampleMin, 1'b1);
    send_sample(SampleMax, 1'b1);
    send_sample(100000, 1'b1);
    send_sample(89934, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    settle();

    // crossed limits, immediate toggle; unmapped indexes must be ignored
    program_regs(ThrWidth'(300000), ThrWidth'(200000), '0, '0);
    cfg_write(RegUnmapped, $urandom);
    cfg_write(RegTopIndex, $urandom);
    send_sample(150000, 1'b1);
    send_sample(300001, 1'b0);
    send_sample(300000, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMax, 1'b1);
    send_sample(299999, 1'b1);
    settle();

    program_regs(ResetMinThreshold, ResetMaxThreshold, ResetOffset, ResetRunLimit);
    play_random(120, 40);
    settle();

    program_regs('0, '1, '0, '0);
    play_random(100, -1);
    settle();

    program_regs('1, '0, '1, RunWidth'(254));
    play_random(60, -1);
    settle();

    // run limit 255: the run counter saturates and detection never toggles
    begin
      logic [ThrWidth-1:0] mn;
      mn = ThrWidth'($urandom_range(0, 200000));
      program_regs(mn, mn + ThrWidth'($urandom_range(0, 500000)),
                   ThrWidth'($urandom_range(0, 50000)), '1);
    end
    play_random(350, -1);
    settle();

    program_regs(ThrWidth'($urandom_range(0, ThrMax)), ThrWidth'($urandom_range(0, ThrMax)),
                 ThrWidth'($urandom_range(0, ThrMax)), RunWidth'($urandom_range(0, 40)));
    play_random(150, -1);
    settle();

    // closing phase runs at full rate on both sides
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    program_regs(ThrWidth'($urandom_range(0, 100000)), ThrWidth'($urandom_range(100000, 600000)),
                 ThrWidth'($urandom_range(0, 30000)), RunWidth'($urandom_range(0, 10)));
    play_random(150, -1);
    settle();
    repeat (4) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("adaptive_threshold_tone_detector: match");
    else
      $display("adaptive_threshold_tone_detector: mismatch");
    $finish;
  end

endmodule
